// ===== hw/rtl/hga_pkg.sv =====
// ----------------------------------------------------------------------------
// hga_pkg
// shared constants and types for the generational handle allocator
// ----------------------------------------------------------------------------
package hga_pkg;

  localparam int CAPACITY  = 1024;
  localparam int GEN_BITS  = 16;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int FILL_W    = $clog2(CAPACITY + 1);
  localparam int GEN_CMP_W = (GEN_BITS > 16) ? GEN_BITS : 16;

  typedef enum logic [1:0] {
    OP_CREATE  = 2'd0,
    OP_DESTROY = 2'd1,
    OP_QUERY   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_STALE     = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD_FIFO,
    S_EXEC,
    S_OUT
  } state_t;

endpackage

// ===== hw/rtl/hga_ram.sv =====
// ----------------------------------------------------------------------------
// hga_ram
// single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module hga_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/generational_handle_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// generational_handle_allocator_unit
// hands out generation-tagged slot handles from a free-slot fifo; destroy
// bumps the slot generation and returns the slot, query checks liveness
// ----------------------------------------------------------------------------
// stages: generation read, execute, output register; on create the
//   generation read address is the slot already waiting at the fifo ram
//   output.
// flow: in_ready only in idle state, so no new item is taken until the last
//   result has gone to the output register, longer while an output beat waits.
// reset: synchronous rst starts a clearing pass over every address that loads
//   both rams (generations 0/1, fifo 1..CAPACITY-1); no input beat until done.
// ----------------------------------------------------------------------------
module generational_handle_allocator_unit
  import hga_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [9:0]  handle_index,
  input  logic [15:0] handle_generation,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [9:0]  out_index,
  output logic [15:0] out_generation,
  output logic        alive,
  output logic [9:0]  live_count
);

  state_t state, state_next;

  logic [IDX_W-1:0]  clr_addr;
  logic [IDX_W-1:0]  head;
  logic [IDX_W-1:0]  tail;
  logic [FILL_W-1:0] fill;
  logic [IDX_W-1:0]  live_total;

  logic [1:0]        op_q;
  logic [9:0]        idx_q;
  logic [15:0]       gen_q;
  logic [IDX_W-1:0]  slot_q;

  logic [1:0]        res_status;
  logic [9:0]        res_index;
  logic [15:0]       res_generation;
  logic              res_alive;

  logic              gen_we;
  logic [IDX_W-1:0]  gen_waddr;
  logic [GEN_BITS-1:0] gen_wdata;
  logic [IDX_W-1:0]  gen_raddr;
  logic [GEN_BITS-1:0] gen_rdata;

  logic              fifo_we;
  logic [IDX_W-1:0]  fifo_waddr;
  logic [IDX_W-1:0]  fifo_wdata;
  logic [IDX_W-1:0]  fifo_rdata;

  logic              in_beat;
  logic              out_free;
  logic              idx_ok;
  logic              live_hit;
  logic              fill_empty;
  logic              fill_room;
  logic [GEN_BITS-1:0] gen_inc;
  logic [GEN_BITS-1:0] gen_bumped;
  logic [IDX_W-1:0]  clr_fifo_val;

  hga_ram #(.WIDTH(GEN_BITS), .DEPTH(CAPACITY)) u_gen_ram (
    .clk   (clk),
    .we    (gen_we),
    .waddr (gen_waddr),
    .wdata (gen_wdata),
    .raddr (gen_raddr),
    .rdata (gen_rdata)
  );

  hga_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_fifo_ram (
    .clk   (clk),
    .we    (fifo_we),
    .waddr (fifo_waddr),
    .wdata (fifo_wdata),
    .raddr (head),
    .rdata (fifo_rdata)
  );

  function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] p);
    logic [IDX_W-1:0] r;
    if (p == IDX_W'(CAPACITY - 1)) begin
      r = '0;
    end else begin
      r = p + IDX_W'(1);
    end
    return r;
  endfunction

  assign in_ready = (state == S_IDLE);
  assign in_beat  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  assign idx_ok   = (32'(idx_q) != 32'd0) && (32'(idx_q) < CAPACITY);
  assign live_hit = idx_ok && (gen_rdata != '0) &&
                    (GEN_CMP_W'(gen_rdata) == GEN_CMP_W'(gen_q));
  assign fill_empty = (fill == '0);
  assign fill_room  = (fill < FILL_W'(CAPACITY));
  assign gen_inc    = gen_rdata + GEN_BITS'(1);
  assign gen_bumped = (gen_inc == '0) ? GEN_BITS'(1) : gen_inc;
  assign clr_fifo_val = (clr_addr == IDX_W'(CAPACITY - 1)) ? '0 : clr_addr + IDX_W'(1);

  // generation read address
  always_comb begin
    if (op_q == OP_CREATE) begin
      gen_raddr = fifo_rdata;
    end else begin
      gen_raddr = IDX_W'(idx_q);
    end
  end

  // ram write ports
  always_comb begin
    gen_we     = 1'b0;
    gen_waddr  = IDX_W'(idx_q);
    gen_wdata  = gen_bumped;
    fifo_we    = 1'b0;
    fifo_waddr = tail;
    fifo_wdata = IDX_W'(idx_q);
    if (state == S_CLEAR) begin
      gen_we     = 1'b1;
      gen_waddr  = clr_addr;
      gen_wdata  = (clr_addr == '0) ? '0 : GEN_BITS'(1);
      fifo_we    = 1'b1;
      fifo_waddr = clr_addr;
      fifo_wdata = clr_fifo_val;
    end else if (state == S_EXEC && op_q == OP_DESTROY && live_hit) begin
      gen_we  = 1'b1;
      fifo_we = fill_room;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_addr == IDX_W'(CAPACITY - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_beat) begin
          state_next = S_RD_FIFO;
        end
      end
      S_RD_FIFO: begin
        state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // control counters and pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr   <= '0;
      head       <= '0;
      tail       <= IDX_W'(CAPACITY - 1);
      fill       <= FILL_W'(CAPACITY - 1);
      live_total <= '0;
    end else begin
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + IDX_W'(1);
      end
      if (state == S_EXEC) begin
        unique case (op_q)
          OP_CREATE: begin
            if (!fill_empty) begin
              head <= wrap_next(head);
              fill <= fill - FILL_W'(1);
              if (live_total < IDX_W'(CAPACITY - 1)) begin
                live_total <= live_total + IDX_W'(1);
              end
            end
          end
          OP_DESTROY: begin
            if (live_hit) begin
              if (fill_room) begin
                tail <= wrap_next(tail);
                fill <= fill + FILL_W'(1);
              end
              if (live_total != '0) begin
                live_total <= live_total - IDX_W'(1);
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // input capture and result payload
  always_ff @(posedge clk) begin
    if (in_beat) begin
      op_q  <= opcode;
      idx_q <= handle_index;
      gen_q <= handle_generation;
    end
    if (state == S_RD_FIFO) begin
      slot_q <= fifo_rdata;
    end
    if (state == S_EXEC) begin
      res_status     <= ST_STALE;
      res_index      <= '0;
      res_generation <= '0;
      res_alive      <= 1'b0;
      unique case (op_q)
        OP_CREATE: begin
          if (fill_empty) begin
            res_status <= ST_EXHAUSTED;
          end else begin
            res_status     <= ST_OK;
            res_index      <= 10'(slot_q);
            res_generation <= 16'(gen_rdata);
          end
        end
        OP_DESTROY, OP_QUERY: begin
          if (live_hit) begin
            res_status <= ST_OK;
            res_alive  <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      status         <= res_status;
      out_index      <= res_index;
      out_generation <= res_generation;
      alive          <= res_alive;
      live_count     <= 10'(live_total);
    end
  end

endmodule
